[rtl/jsu_pkg.sv]
// ----------------------------------------------------------------------------
// jsu_pkg
// shared types, status codes and helpers for the json string unescaper
// ----------------------------------------------------------------------------
package jsu_pkg;

    // status codes of a result word
    localparam logic [3:0] StBusy    = 4'd0;
    localparam logic [3:0] StDone    = 4'd1;
    localparam logic [3:0] StNoQuote = 4'd2;
    localparam logic [3:0] StControl = 4'd3;
    localparam logic [3:0] StOpenEsc = 4'd4;
    localparam logic [3:0] StShortU  = 4'd5;
    localparam logic [3:0] StBadHex  = 4'd6;
    localparam logic [3:0] StBadEsc  = 4'd7;
    localparam logic [3:0] StUnterm  = 4'd8;

    // request types
    localparam logic ReqByte = 1'b0;
    localparam logic ReqEnd  = 1'b1;

    // result queue depth, room for three results of one input plus one in flight
    localparam int QDepth = 4;
    localparam int QAw    = $clog2(QDepth);

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic [3:0] status;
        logic       last;
    } t_res;

    // results of one decoded input word
    typedef struct packed {
        logic [1:0]      num;
        t_res [2:0]      items;
    } t_dec;

    // hex digit value, bit 4 set when the byte is a hex digit
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            v = {1'b1, c[3:0] + 4'd9};
        end
        return v;
    endfunction

endpackage

[rtl/jsu_if.sv]
// ----------------------------------------------------------------------------
// jsu_if
// valid/ready channels for text bytes in and decoded results out
// ----------------------------------------------------------------------------
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] in_byte;

    modport source (output valid, output req_type, output in_byte, input ready);
    modport sink (input valid, input req_type, input in_byte, output ready);
endinterface

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [3:0] status;
    logic       last;

    modport source (output valid, output out_byte, output byte_valid, output status,
                    output last, input ready);
    modport sink (input valid, input out_byte, input byte_valid, input status,
                  input last, output ready);
endinterface

[rtl/jsu_decode.sv]
// ----------------------------------------------------------------------------
// jsu_decode
// escape state machine, decodes one text word into up to three results
// ----------------------------------------------------------------------------
module jsu_decode (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_req_type,
    input  logic [7:0]       i_byte,
    output jsu_pkg::t_dec    o_dec
);

    localparam logic [1:0] PhIdle = 2'd0;
    localparam logic [1:0] PhStr  = 2'd1;
    localparam logic [1:0] PhEsc  = 2'd2;
    localparam logic [1:0] PhHex  = 2'd3;

    logic [1:0]  r_phase, n_phase;
    logic [1:0]  r_hex_cnt, n_hex_cnt;
    logic [15:0] r_cp, n_cp;

    logic        eot;
    logic [4:0]  hv;
    logic [15:0] cp_new;

    assign eot    = (i_req_type == jsu_pkg::ReqEnd);
    assign hv     = jsu_pkg::hex_val(i_byte);
    assign cp_new = {r_cp[11:0], hv[3:0]};

    always_comb begin
        jsu_pkg::t_dec d;
        logic [3:0]    fin_st;
        logic          fin;
        d         = '0;
        fin       = 1'b0;
        fin_st    = jsu_pkg::StBusy;
        n_phase   = r_phase;
        n_hex_cnt = r_hex_cnt;
        n_cp      = r_cp;

        unique case (r_phase)
            PhIdle: begin
                if (eot) begin
                    fin = 1'b1; fin_st = jsu_pkg::StNoQuote;
                end else if (i_byte == 8'h20 || i_byte == 8'h09 ||
                             i_byte == 8'h0A || i_byte == 8'h0D) begin
                    n_phase = PhIdle;
                end else if (i_byte == 8'h22) begin
                    n_phase = PhStr;
                end else begin
                    fin = 1'b1; fin_st = jsu_pkg::StNoQuote;
                end
            end
            PhStr: begin
                if (eot) begin
                    fin = 1'b1; fin_st = jsu_pkg::StUnterm;
                end else if (i_byte == 8'h22) begin
                    fin = 1'b1; fin_st = jsu_pkg::StDone;
                end else if (i_byte < 8'h20) begin
                    fin = 1'b1; fin_st = jsu_pkg::StControl;
                end else if (i_byte == 8'h5C) begin
                    n_phase = PhEsc;
                end else begin
                    d.num      = 2'd1;
                    d.items[0] = '{out_byte: i_byte, byte_valid: 1'b1,
                                   status: jsu_pkg::StBusy, last: 1'b1};
                end
            end
            PhEsc: begin
                if (eot) begin
                    fin = 1'b1; fin_st = jsu_pkg::StOpenEsc;
                end else begin
                    d.items[0] = '{out_byte: 8'h00, byte_valid: 1'b1,
                                   status: jsu_pkg::StBusy, last: 1'b1};
                    d.num      = 2'd1;
                    n_phase    = PhStr;
                    unique case (i_byte) inside
                        8'h22, 8'h5C, 8'h2F: d.items[0].out_byte = i_byte;
                        8'h62:               d.items[0].out_byte = 8'h08;
                        8'h66:               d.items[0].out_byte = 8'h0C;
                        8'h6E:               d.items[0].out_byte = 8'h0A;
                        8'h72:               d.items[0].out_byte = 8'h0D;
                        8'h74:               d.items[0].out_byte = 8'h09;
                        8'h75: begin
                            d         = '0;
                            n_phase   = PhHex;
                            n_hex_cnt = 2'd0;
                            n_cp      = 16'd0;
                        end
                        default: begin
                            fin = 1'b1; fin_st = jsu_pkg::StBadEsc;
                        end
                    endcase
                end
            end
            PhHex: begin
                if (eot) begin
                    fin = 1'b1; fin_st = jsu_pkg::StShortU;
                end else if (!hv[4]) begin
                    fin = 1'b1; fin_st = jsu_pkg::StBadHex;
                end else if (r_hex_cnt == 2'd3) begin
                    n_phase   = PhStr;
                    n_hex_cnt = 2'd0;
                    n_cp      = 16'd0;
                    // utf-8 encoding of the code point
                    if (cp_new <= 16'h007F) begin
                        d.num      = 2'd1;
                        d.items[0] = '{out_byte: cp_new[7:0], byte_valid: 1'b1,
                                       status: jsu_pkg::StBusy, last: 1'b1};
                    end else if (cp_new <= 16'h07FF) begin
                        d.num      = 2'd2;
                        d.items[0] = '{out_byte: 8'hC0 | {3'b000, cp_new[10:6]},
                                       byte_valid: 1'b1, status: jsu_pkg::StBusy,
                                       last: 1'b0};
                        d.items[1] = '{out_byte: 8'h80 | {2'b00, cp_new[5:0]},
                                       byte_valid: 1'b1, status: jsu_pkg::StBusy,
                                       last: 1'b1};
                    end else begin
                        d.num      = 2'd3;
                        d.items[0] = '{out_byte: 8'hE0 | {4'h0, cp_new[15:12]},
                                       byte_valid: 1'b1, status: jsu_pkg::StBusy,
                                       last: 1'b0};
                        d.items[1] = '{out_byte: 8'h80 | {2'b00, cp_new[11:6]},
                                       byte_valid: 1'b1, status: jsu_pkg::StBusy,
                                       last: 1'b0};
                        d.items[2] = '{out_byte: 8'h80 | {2'b00, cp_new[5:0]},
                                       byte_valid: 1'b1, status: jsu_pkg::StBusy,
                                       last: 1'b1};
                    end
                end else begin
                    n_cp      = cp_new;
                    n_hex_cnt = r_hex_cnt + 2'd1;
                end
            end
            default: n_phase = PhIdle;
        endcase

        if (fin) begin
            d          = '0;
            d.num      = 2'd1;
            d.items[0] = '{out_byte: 8'h00, byte_valid: 1'b0, status: fin_st, last: 1'b1};
            n_phase    = PhIdle;
            n_hex_cnt  = 2'd0;
            n_cp       = 16'd0;
        end
        o_dec = d;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PhIdle;
            r_hex_cnt <= 2'd0;
            r_cp      <= 16'd0;
        end else if (i_adv) begin
            r_phase   <= n_phase;
            r_hex_cnt <= n_hex_cnt;
            r_cp      <= n_cp;
        end
    end

endmodule

[rtl/jsu_resq.sv]
// ----------------------------------------------------------------------------
// jsu_resq
// result queue, takes up to three results a cycle and hands out one while ready is high
// ----------------------------------------------------------------------------
module jsu_resq (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [1:0]              i_push_num,
    input  jsu_pkg::t_res [2:0]     i_items,
    output logic [jsu_pkg::QAw:0]   o_free,
    jsu_out_if.source               o_out
);

    localparam int Aw = jsu_pkg::QAw;

    jsu_pkg::t_res     r_mem [jsu_pkg::QDepth];
    logic [Aw-1:0]     r_wp, r_rp;
    logic [Aw:0]       r_cnt, n_cnt;
    logic              pop;

    assign pop    = (r_cnt != '0) && o_out.ready;
    assign n_cnt  = r_cnt + (Aw+1)'(i_push_num) - (Aw+1)'(pop);
    assign o_free = (Aw+1)'(jsu_pkg::QDepth) - r_cnt;

    assign o_out.valid      = (r_cnt != '0);
    assign o_out.out_byte   = r_mem[r_rp].out_byte;
    assign o_out.byte_valid = r_mem[r_rp].byte_valid;
    assign o_out.status     = r_mem[r_rp].status;
    assign o_out.last       = r_mem[r_rp].last;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            if (2'(k) < i_push_num) begin
                r_mem[r_wp + Aw'(k)] <= i_items[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + Aw'(i_push_num);
            r_rp  <= r_rp + Aw'(pop);
            r_cnt <= n_cnt;
        end
    end

endmodule

[rtl/json_string_unescaper_unit.sv]
// ----------------------------------------------------------------------------
// json_string_unescaper_unit
// streaming json string literal decoder with utf-8 output for \u escapes
// ----------------------------------------------------------------------------
// path: an accepted word is held in the input register and decoded from it;
//   once committed, its results go into the four-entry result queue
// throughput: one text word per cycle while the queue has room; a \u escape
//   yields up to three result words, drained one per cycle while ready is high
// reset: synchronous active-low, returns to idle awaiting the opening quote
//   with an empty queue and no word held in the input register
// ----------------------------------------------------------------------------
module json_string_unescaper_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    jsu_in_if.sink     i_in,
    jsu_out_if.source  o_out
);

    // input register
    logic       r_vld;
    logic       r_req_type;
    logic [7:0] r_byte;

    // decoded results of the held word
    jsu_pkg::t_dec            dec;
    logic [jsu_pkg::QAw:0]    q_free;
    logic                     adv;

    // the held word moves on once the queue has room for all of its results
    assign adv        = r_vld && ({1'b0, dec.num} <= q_free);
    // the input register refills whenever it is empty or draining this cycle
    assign i_in.ready = !r_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_vld <= i_in.valid;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_req_type <= i_in.req_type;
            r_byte     <= i_in.in_byte;
        end
    end

    // escape state machine, state only updates when the word is committed
    jsu_decode u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_req_type (r_req_type),
        .i_byte     (r_byte),
        .o_dec      (dec)
    );

    // result queue decouples multi-byte utf-8 bursts from the output side
    jsu_resq u_resq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_num (adv ? dec.num : 2'd0),
        .i_items    (dec.items),
        .o_free     (q_free),
        .o_out      (o_out)
    );

endmodule

[dv/json_string_unescaper_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescaper_unit_tb
// self-checking bench: streams json string literals, both well-formed and
// broken, through the unescaper and compares every decoded word against a
// local decoder with its own phase, hex digit count and code point
// ----------------------------------------------------------------------------
module json_string_unescaper_unit_tb;
    import jsu_pkg::*;

    // characters with a meaning of their own in the text
    localparam logic [7:0] ChQuote  = 8'h22;
    localparam logic [7:0] ChBslash = 8'h5C;
    localparam logic [7:0] ChSlash  = 8'h2F;
    localparam logic [7:0] ChU      = 8'h75;
    localparam logic [7:0] ChSpace  = 8'h20;
    localparam logic [7:0] ChTab    = 8'h09;
    localparam logic [7:0] ChLf     = 8'h0A;
    localparam logic [7:0] ChCr     = 8'h0D;

    // first byte that may stand raw inside a literal
    localparam logic [7:0] PrintMin = 8'h20;

    localparam int RandomWords = 430;
    localparam int DrainCycles = 12;
    localparam int CycleLimit  = 200_000;

    typedef enum logic [1:0] {PhIdle, PhStr, PhEsc, PhHex} t_phase;

    typedef struct packed {
        logic       req;
        logic [7:0] b;
    } t_text_word;

    // ------------------------------------------------------------------------
    // decoder of the literal and store of the words it should produce
    // ------------------------------------------------------------------------
    class literal_decoder;
        t_phase      ph;
        logic [1:0]  hex_cnt;
        logic [15:0] cp_acc;
        t_res        decoded_q[$];
        int unsigned fail_cnt;

        function new();
            ph       = PhIdle;
            hex_cnt  = 2'd0;
            cp_acc   = 16'd0;
            fail_cnt = 0;
        endfunction

        function bit is_blank(logic [7:0] c);
            return c == ChSpace || c == ChTab || c == ChLf || c == ChCr;
        endfunction

        function int nibble_of(logic [7:0] c);
            if (c >= "0" && c <= "9") return c - "0";
            if (c >= "a" && c <= "f") return c - "a" + 10;
            if (c >= "A" && c <= "F") return c - "A" + 10;
            return -1;
        endfunction

        // one-byte escapes; the letter u is handled apart
        function bit simple_escape(input logic [7:0] c, output logic [7:0] b);
            b = 8'h00;
            case (c) inside
                ChQuote, ChBslash, ChSlash: b = c;
                "b": b = 8'h08;
                "f": b = 8'h0C;
                "n": b = ChLf;
                "r": b = ChCr;
                "t": b = ChTab;
                default: return 1'b0;
            endcase
            return 1'b1;
        endfunction

        function void push_byte(logic [7:0] b, bit fin);
            t_res r;
            r.out_byte   = b;
            r.byte_valid = 1'b1;
            r.status     = StBusy;
            r.last       = fin;
            decoded_q.push_back(r);
        endfunction

        function void close(logic [3:0] st);
            t_res r;
            r.out_byte   = 8'h00;
            r.byte_valid = 1'b0;
            r.status     = st;
            r.last       = 1'b1;
            decoded_q.push_back(r);
            ph      = PhIdle;
            hex_cnt = 2'd0;
            cp_acc  = 16'd0;
        endfunction

        function void push_utf8(logic [15:0] cp);
            if (cp <= 16'h007F) begin
                push_byte(cp[7:0], 1'b1);
            end else if (cp <= 16'h07FF) begin
                push_byte({3'b110, cp[10:6]}, 1'b0);
                push_byte({2'b10, cp[5:0]}, 1'b1);
            end else begin
                push_byte({4'b1110, cp[15:12]}, 1'b0);
                push_byte({2'b10, cp[11:6]}, 1'b0);
                push_byte({2'b10, cp[5:0]}, 1'b1);
            end
        endfunction

        // called once per accepted text word
        function void decode_word(logic req, logic [7:0] c);
            logic [7:0] b;
            int         h;
            case (ph)
                PhIdle: begin
                    if (req == ReqEnd || !(is_blank(c) || c == ChQuote)) begin
                        close(StNoQuote);
                    end else if (c == ChQuote) begin
                        ph = PhStr;
                    end
                end
                PhStr: begin
                    if (req == ReqEnd) begin
                        close(StUnterm);
                    end else if (c == ChQuote) begin
                        close(StDone);
                    end else if (c < PrintMin) begin
                        close(StControl);
                    end else if (c == ChBslash) begin
                        ph = PhEsc;
                    end else begin
                        push_byte(c, 1'b1);
                    end
                end
                PhEsc: begin
                    if (req == ReqEnd) begin
                        close(StOpenEsc);
                    end else if (c == ChU) begin
                        ph      = PhHex;
                        hex_cnt = 2'd0;
                        cp_acc  = 16'd0;
                    end else if (simple_escape(c, b)) begin
                        ph = PhStr;
                        push_byte(b, 1'b1);
                    end else begin
                        close(StBadEsc);
                    end
                end
                default: begin
                    h = nibble_of(c);
                    if (req == ReqEnd) begin
                        close(StShortU);
                    end else if (h < 0) begin
                        close(StBadHex);
                    end else begin
                        cp_acc = {cp_acc[11:0], h[3:0]};
                        if (hex_cnt == 2'd3) begin
                            ph      = PhStr;
                            hex_cnt = 2'd0;
                            push_utf8(cp_acc);
                            cp_acc  = 16'd0;
                        end else begin
                            hex_cnt = hex_cnt + 2'd1;
                        end
                    end
                end
            endcase
        endfunction

        function void compare_field(string field, int want, int got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, field, want, got);
                fail_cnt++;
            end
        endfunction

        function void check_result(t_res got);
            t_res want;
            if (decoded_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0h/%0b/%0d/%0b",
                         $time, got.out_byte, got.byte_valid, got.status, got.last);
                fail_cnt++;
                return;
            end
            want = decoded_q.pop_front();
            compare_field("out_byte", want.out_byte, got.out_byte);
            compare_field("byte_valid", want.byte_valid, got.byte_valid);
            compare_field("status", want.status, got.status);
            compare_field("last", want.last, got.last);
        endfunction

        function int pending();
            return decoded_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    jsu_in_if  in_ch ();
    jsu_out_if out_ch ();

    json_string_unescaper_unit u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    literal_decoder decoder;
    t_text_word     text_q[$];

    // ------------------------------------------------------------------------
    // text generation
    // ------------------------------------------------------------------------
    function void add_word(logic req, logic [7:0] b);
        t_text_word w;
        w.req = req;
        w.b   = b;
        text_q.push_back(w);
    endfunction

    function logic [7:0] pick_blank();
        case ($urandom_range(0, 3))
            0: return ChSpace;
            1: return ChTab;
            2: return ChLf;
            default: return ChCr;
        endcase
    endfunction

    // hex digit in either case, chosen at random
    function void add_hex_digit(logic [3:0] n);
        logic [7:0] ch;
        if (n < 4'd10) begin
            ch = "0" + n;
        end else if ($urandom_range(0, 1)) begin
            ch = "A" + (n - 4'd10);
        end else begin
            ch = "a" + (n - 4'd10);
        end
        add_word(ReqByte, ch);
    endfunction

    function void add_unicode(logic [15:0] cp);
        add_word(ReqByte, ChBslash);
        add_word(ReqByte, ChU);
        for (int i = 3; i >= 0; i--) begin
            add_hex_digit(cp[i*4 +: 4]);
        end
    endfunction

    // code point from one of the utf-8 length classes, surrogates and edges
    function logic [15:0] pick_code_point();
        case ($urandom_range(0, 4))
            0: return 16'($urandom_range(16'h0000, 16'h007F));
            1: return 16'($urandom_range(16'h0080, 16'h07FF));
            2: return 16'($urandom_range(16'h0800, 16'hFFFF));
            3: return 16'($urandom_range(16'hD800, 16'hDFFF));
            default: begin
                case ($urandom_range(0, 5))
                    0: return 16'h0000;
                    1: return 16'h007F;
                    2: return 16'h0080;
                    3: return 16'h07FF;
                    4: return 16'h0800;
                    default: return 16'hFFFF;
                endcase
            end
        endcase
    endfunction

    // one piece of literal body: raw byte, short escape or \u escape
    function void add_segment();
        logic [7:0] b;
        case ($urandom_range(0, 3))
            0, 1: begin
                do begin
                    b = 8'($urandom_range(PrintMin, 8'hFF));
                end while (b == ChQuote || b == ChBslash);
                add_word(ReqByte, b);
            end
            2: begin
                add_word(ReqByte, ChBslash);
                case ($urandom_range(0, 7))
                    0: add_word(ReqByte, ChQuote);
                    1: add_word(ReqByte, ChBslash);
                    2: add_word(ReqByte, ChSlash);
                    3: add_word(ReqByte, "b");
                    4: add_word(ReqByte, "f");
                    5: add_word(ReqByte, "n");
                    6: add_word(ReqByte, "r");
                    default: add_word(ReqByte, "t");
                endcase
            end
            default: add_unicode(pick_code_point());
        endcase
    endfunction

    // mostly well-formed literals; some broken at the start or at the end
    function void add_literal();
        logic [7:0] b;
        logic [7:0] dummy;
        repeat ($urandom_range(0, 2)) add_word(ReqByte, pick_blank());

        // stray words of any kind, now and then
        if ($urandom_range(0, 29) == 0) begin
            repeat ($urandom_range(1, 4)) begin
                add_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end
            return;
        end

        // missing opening quote
        if ($urandom_range(0, 19) == 0) begin
            if ($urandom_range(0, 1)) begin
                add_word(ReqEnd, 8'($urandom_range(0, 255)));
            end else begin
                do begin
                    b = 8'($urandom_range(0, 255));
                end while (decoder.is_blank(b) || b == ChQuote);
                add_word(ReqByte, b);
            end
            return;
        end

        add_word(ReqByte, ChQuote);
        repeat ($urandom_range(0, 8)) add_segment();

        case ($urandom_range(0, 15))
            0: add_word(ReqByte, 8'($urandom_range(8'h00, PrintMin - 8'h01)));
            1: add_word(ReqEnd, 8'($urandom_range(0, 255)));
            2: begin
                add_word(ReqByte, ChBslash);
                add_word(ReqEnd, 8'($urandom_range(0, 255)));
            end
            3, 4: begin
                add_word(ReqByte, ChBslash);
                add_word(ReqByte, ChU);
                repeat ($urandom_range(0, 3)) add_hex_digit(4'($urandom_range(0, 15)));
                if ($urandom_range(0, 1)) begin
                    add_word(ReqEnd, 8'($urandom_range(0, 255)));
                end else begin
                    do begin
                        b = 8'($urandom_range(0, 255));
                    end while (decoder.nibble_of(b) >= 0);
                    add_word(ReqByte, b);
                end
            end
            5: begin
                add_word(ReqByte, ChBslash);
                do begin
                    b = 8'($urandom_range(0, 255));
                end while (decoder.simple_escape(b, dummy) || b == ChU);
                add_word(ReqByte, b);
            end
            default: add_word(ReqByte, ChQuote);
        endcase
    endfunction

    // short hand-picked text: whitespace skip, edge bytes, three-byte \u,
    // and one literal for each error kind
    function void add_directed();
        add_word(ReqByte, ChSpace);
        add_word(ReqByte, ChTab);
        add_word(ReqByte, ChCr);
        add_word(ReqByte, ChLf);
        add_word(ReqByte, ChQuote);
        add_word(ReqByte, PrintMin);
        add_word(ReqByte, 8'h7F);
        add_word(ReqByte, 8'hFF);
        add_word(ReqByte, ChBslash);
        add_word(ReqByte, ChU);
        add_word(ReqByte, "F");
        add_word(ReqByte, "f");
        add_word(ReqByte, "f");
        add_word(ReqByte, "F");
        add_word(ReqByte, ChQuote);
        // end of text while idle, then a stray byte while idle
        add_word(ReqEnd, 8'hA5);
        add_word(ReqByte, "x");
        // raw control byte
        add_word(ReqByte, ChQuote);
        add_word(ReqByte, 8'h1F);
        // end of text right after a backslash
        add_word(ReqByte, ChQuote);
        add_word(ReqByte, ChBslash);
        add_word(ReqEnd, 8'h5A);
        // unknown escape letter
        add_word(ReqByte, ChQuote);
        add_word(ReqByte, ChBslash);
        add_word(ReqByte, "q");
        // end of text inside the literal
        add_word(ReqByte, ChQuote);
        add_word(ReqEnd, 8'h00);
        // end of text among the hex digits
        add_word(ReqByte, ChQuote);
        add_word(ReqByte, ChBslash);
        add_word(ReqByte, ChU);
        add_word(ReqByte, "7");
        add_word(ReqEnd, 8'hFF);
        // non-hex byte as the first digit
        add_word(ReqByte, ChQuote);
        add_word(ReqByte, ChBslash);
        add_word(ReqByte, ChU);
        add_word(ReqByte, "g");
    endfunction

    // ------------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------------
    // hold the word until the block takes it, then let the decoder see it
    task automatic send_word(t_text_word w);
        in_ch.valid    <= 1'b1;
        in_ch.req_type <= w.req;
        in_ch.in_byte  <= w.b;
        do @(posedge clk); while (!in_ch.ready);
        decoder.decode_word(w.req, w.b);
    endtask

    // drop valid and scramble the payload for the given idle gap
    task automatic go_idle(int cycles);
        in_ch.valid    <= 1'b0;
        in_ch.req_type <= 1'($urandom_range(0, 1));
        in_ch.in_byte  <= 8'($urandom_range(0, 255));
        repeat (cycles) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // receiver side: the stall mode is redrawn at random after a random number of cycles
    // ------------------------------------------------------------------------
    int stall_mode  = 0;
    int mode_left   = 0;
    int pattern_cnt = 0;

    always @(posedge clk) begin : result_sink
        t_res seen;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            seen.out_byte   = out_ch.out_byte;
            seen.byte_valid = out_ch.byte_valid;
            seen.status     = out_ch.status;
            seen.last       = out_ch.last;
            decoder.check_result(seen);
        end

        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(16, 96);
        end else begin
            mode_left--;
        end
        pattern_cnt++;

        // always ready, coin toss, or one cycle in four
        case (stall_mode)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= 1'($urandom_range(0, 1));
            default: out_ch.ready <= (pattern_cnt % 4 == 0);
        endcase
    end

    // ------------------------------------------------------------------------
    // run watchdog
    // ------------------------------------------------------------------------
    int cycle_cnt = 0;

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CycleLimit) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int sent;
        int burst;
        int gap;
        int target;

        decoder = new();
        rst_n          <= 1'b0;
        in_ch.valid    <= 1'b0;
        in_ch.req_type <= ReqByte;
        in_ch.in_byte  <= 8'h00;

        add_directed();
        target = text_q.size() + RandomWords;
        while (text_q.size() < target) add_literal();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // bursts of random length; the odd long one keeps valid high for a while
        sent = 0;
        while (sent < text_q.size()) begin
            if ($urandom_range(0, 7) == 0) begin
                burst = $urandom_range(30, 80);
            end else begin
                burst = $urandom_range(1, 12);
            end
            for (int k = 0; k < burst && sent < text_q.size(); k++) begin
                send_word(text_q[sent]);
                sent++;
            end
            gap = $urandom_range(0, 4);
            if (gap > 0) go_idle(gap);
        end
        in_ch.valid <= 1'b0;

        // drain, then give stray words time to show up
        while (decoder.pending() != 0) @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        if (decoder.fail_cnt == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/jsu_pkg.sv
rtl/jsu_if.sv
rtl/jsu_decode.sv
rtl/jsu_resq.sv
rtl/json_string_unescaper_unit.sv
dv/json_string_unescaper_unit_tb.sv
